// ===== src/gc_mark_bitmap_unit_core_defines.svh =====
// assertion macros used by the mark bitmap unit checker
`ifndef GC_MARK_BITMAP_UNIT_CORE_DEFINES_SVH
`define GC_MARK_BITMAP_UNIT_CORE_DEFINES_SVH

// antecedent implies consequent in the next cycle
`define GMB_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("gmb check failed");

// antecedent implies consequent at a later cycle than GMB_ASSERT_NEXT checks
`define GMB_ASSERT_NEXT2(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> ##1 (cons)) \
		else $error("gmb check failed");

`endif

// ===== src/gmb_pkg.sv =====
// shared types and constants of the mark bitmap unit
package gmb_pkg;

	localparam int TYPE_W      = 3;
	localparam int ADDR_W      = 32;
	localparam int HIDX_W      = 3;
	localparam int STAT_W      = 2;
	localparam int TBL_N       = 2 ** HIDX_W;
	localparam int IN_TDATA_W  = 104;
	localparam int IN_TUSER_W  = 4;
	localparam int OUT_TDATA_W = 8;

	typedef enum logic [TYPE_W-1:0] {
		REQ_MARK   = 3'd0,
		REQ_TEST   = 3'd1,
		REQ_CLEAR  = 3'd2,
		REQ_DEFINE = 3'd3,
		REQ_FORGET = 3'd4
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_OFF_HEAP  = 2'd1,
		ST_TOO_LARGE = 2'd2,
		ST_OUTSIDE   = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic look;
		logic rd;
		logic finish;
		logic clr;
	} gmb_cmd_t;

endpackage

// ===== src/gmb_ram.sv =====
// generic single write port ram with registered read
module gmb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/gmb_ctrl.sv =====
// controller state machine of the mark bitmap unit
module gmb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  logic             clr_done,
	output gmb_pkg::gmb_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLR,
		S_IDLE,
		S_LOOK,
		S_RD,
		S_MOD
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_v_q;
	logic   can_fin;

	assign m_tvalid = out_v_q;

	always_comb begin
		can_fin     = (state_q == S_MOD) && (!out_v_q || m_tready);
		s_tready    = (state_q == S_IDLE) || can_fin;
		cmd.capture = s_tvalid && s_tready;
		cmd.look    = (state_q == S_LOOK);
		cmd.rd      = (state_q == S_RD);
		cmd.finish  = can_fin;
		cmd.clr     = (state_q == S_CLR);
		state_d     = state_q;
		case (state_q)
			S_CLR: begin
				if (clr_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cmd.capture) begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = S_RD;
			end
			S_RD: begin
				state_d = S_MOD;
			end
			S_MOD: begin
				if (can_fin) begin
					state_d = cmd.capture ? S_LOOK : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

endmodule

// ===== src/gmb_dpath.sv =====
// datapath: region table, slot cache, bitmap ram and result register
module gmb_dpath #(
	parameter int HEAPS          = 8,
	parameter int SLOTS_PER_HEAP = 16384,
	parameter int WORD_BITS      = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gmb_pkg::gmb_cmd_t                 cmd,
	output logic                              clr_done,
	input  logic [gmb_pkg::TYPE_W-1:0]        req_type,
	input  logic [gmb_pkg::ADDR_W-1:0]        object_addr,
	input  logic                              heap_given,
	input  logic [gmb_pkg::HIDX_W-1:0]        heap_index,
	input  logic [gmb_pkg::ADDR_W-1:0]        region_base,
	input  logic [gmb_pkg::ADDR_W-1:0]        region_limit,
	input  logic                              region_enable,
	output logic                              marked,
	output logic [gmb_pkg::STAT_W-1:0]        status,
	output logic [gmb_pkg::HIDX_W-1:0]        heap_found
);

	localparam int NREG   = (HEAPS < gmb_pkg::TBL_N) ? HEAPS : gmb_pkg::TBL_N;
	localparam int WPH    = (SLOTS_PER_HEAP + WORD_BITS - 1) / WORD_BITS;
	localparam int MEM_D  = NREG * WPH;
	localparam int MEM_AW = (MEM_D > 1) ? $clog2(MEM_D) : 1;
	localparam int OFF_W  = $clog2(SLOTS_PER_HEAP);
	localparam int BIT_W  = $clog2(WORD_BITS);
	localparam int SH     = OFF_W + BIT_W + 1;
	localparam int RECIP  = (2 ** SH + WORD_BITS - 1) / WORD_BITS;
	localparam int REC_W  = SH - BIT_W + 2;
	localparam int PRD_W  = OFF_W + REC_W;
	localparam int AW     = gmb_pkg::ADDR_W;
	localparam int HW     = gmb_pkg::HIDX_W;

	localparam logic [HW:0]         HEAPS_LIM = (HW + 1)'(NREG);
	localparam logic [AW-1:0]       SLOTS_C   = AW'(SLOTS_PER_HEAP);
	localparam logic [MEM_AW-1:0]   WPH_C     = MEM_AW'(WPH);
	localparam logic [PRD_W-1:0]    RECIP_C   = PRD_W'(RECIP);
	localparam logic [BIT_W-1:0]    WB_LO     = BIT_W'(WORD_BITS);
	localparam logic [MEM_AW-1:0]   CLR_LAST  = MEM_AW'(MEM_D - 1);

	// request registers
	logic [gmb_pkg::TYPE_W-1:0] type_q;
	logic [AW-1:0]              addr_q;
	logic                       given_q;
	logic [HW-1:0]              hidx_q;
	logic [AW-1:0]              rbase_q;
	logic [AW-1:0]              rlimit_q;
	logic                       ren_q;

	// region table and cache
	logic [AW-1:0]              base_q  [gmb_pkg::TBL_N];
	logic [AW-1:0]              limit_q [gmb_pkg::TBL_N];
	logic [gmb_pkg::TBL_N-1:0]  valid_q;
	logic                       cache_v_q;
	logic [HW-1:0]              cache_r_q;

	// lookup results
	logic [gmb_pkg::TBL_N-1:0]  hold_v;
	logic [HW-1:0]              first_idx;
	logic                       any_hit;
	logic                       lk_ok;
	logic [HW-1:0]              lk_r;
	logic [gmb_pkg::STAT_W-1:0] lk_status;
	logic [HW-1:0]              lk_found;
	logic                       lk_cache_set;
	logic                       lk_cache_clr;
	logic                       lk_def_wr;
	logic                       lk_def_off;
	logic                       hidx_ok;
	logic                       too_big;
	logic [AW-1:0]              span;
	logic [AW-1:0]              diff;

	// stage registers
	logic                       ok_s1;
	logic [gmb_pkg::TYPE_W-1:0] type_s1;
	logic [HW-1:0]              r_s1;
	logic [OFF_W-1:0]           off_s1;
	logic [gmb_pkg::STAT_W-1:0] status_s1;
	logic [HW-1:0]              found_s1;
	logic [MEM_AW-1:0]          q_s2;
	logic [MEM_AW-1:0]          waddr_s2;

	logic [PRD_W-1:0]           prod;
	logic [MEM_AW-1:0]          quot;
	logic [MEM_AW-1:0]          raddr;
	logic [BIT_W-1:0]           bit_idx;
	logic [WORD_BITS-1:0]       mask;
	logic [WORD_BITS-1:0]       rdata;
	logic [WORD_BITS-1:0]       mod_data;
	logic                       ram_we;
	logic [MEM_AW-1:0]          ram_waddr;
	logic [WORD_BITS-1:0]       ram_wdata;
	logic                       ram_re;
	logic                       mod_we;
	logic [MEM_AW-1:0]          clr_q;

	logic                       marked_q;
	logic [gmb_pkg::STAT_W-1:0] status_q;
	logic [HW-1:0]              found_q;

	assign marked     = marked_q;
	assign status     = status_q;
	assign heap_found = found_q;
	assign clr_done   = (clr_q == CLR_LAST);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q   <= req_type;
			addr_q   <= object_addr;
			given_q  <= heap_given;
			hidx_q   <= heap_index;
			rbase_q  <= region_base;
			rlimit_q <= region_limit;
			ren_q    <= region_enable;
		end
	end

	// parallel region compare
	always_comb begin
		for (int i = 0; i < gmb_pkg::TBL_N; i++) begin
			hold_v[i] = valid_q[i] && (addr_q >= base_q[i]) && (addr_q < limit_q[i]);
		end
		first_idx = '0;
		for (int i = gmb_pkg::TBL_N - 1; i >= 0; i--) begin
			if (hold_v[i]) begin
				first_idx = HW'(i);
			end
		end
		any_hit = |hold_v;
	end

	assign hidx_ok = ({1'b0, hidx_q} < HEAPS_LIM);
	assign span    = rlimit_q - rbase_q;
	assign too_big = (rlimit_q < rbase_q) || (span > SLOTS_C);

	always_comb begin
		lk_ok        = 1'b0;
		lk_r         = '0;
		lk_status    = gmb_pkg::ST_OK;
		lk_found     = '0;
		lk_cache_set = 1'b0;
		lk_cache_clr = 1'b0;
		lk_def_wr    = 1'b0;
		lk_def_off   = 1'b0;
		case (type_q)
			gmb_pkg::REQ_DEFINE: begin
				lk_found = hidx_q;
				if (!hidx_ok) begin
					lk_status = gmb_pkg::ST_TOO_LARGE;
				end else if (!ren_q) begin
					lk_def_off   = 1'b1;
					lk_cache_clr = cache_v_q && (cache_r_q == hidx_q);
				end else if (too_big) begin
					lk_status = gmb_pkg::ST_TOO_LARGE;
				end else begin
					lk_def_wr = 1'b1;
				end
			end
			gmb_pkg::REQ_FORGET: begin
				lk_cache_clr = 1'b1;
			end
			gmb_pkg::REQ_MARK, gmb_pkg::REQ_TEST, gmb_pkg::REQ_CLEAR: begin
				if (given_q) begin
					lk_found = hidx_q;
					if (hold_v[hidx_q]) begin
						lk_ok        = 1'b1;
						lk_r         = hidx_q;
						lk_cache_set = (type_q == gmb_pkg::REQ_TEST);
					end else begin
						lk_status = gmb_pkg::ST_OUTSIDE;
					end
				end else if (cache_v_q && hold_v[cache_r_q]) begin
					lk_ok    = 1'b1;
					lk_r     = cache_r_q;
					lk_found = cache_r_q;
				end else if (any_hit) begin
					lk_ok        = 1'b1;
					lk_r         = first_idx;
					lk_found     = first_idx;
					lk_cache_set = 1'b1;
				end else begin
					lk_status = gmb_pkg::ST_OFF_HEAP;
				end
			end
			default: begin
				lk_ok = 1'b0;
			end
		endcase
	end

	assign diff = addr_q - base_q[lk_r];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			cache_v_q <= 1'b0;
			cache_r_q <= '0;
			for (int i = 0; i < gmb_pkg::TBL_N; i++) begin
				base_q[i]  <= '0;
				limit_q[i] <= '0;
			end
		end else if (cmd.look) begin
			if (lk_def_wr) begin
				base_q[hidx_q]  <= rbase_q;
				limit_q[hidx_q] <= rlimit_q;
				valid_q[hidx_q] <= 1'b1;
			end else if (lk_def_off) begin
				valid_q[hidx_q] <= 1'b0;
			end
			if (lk_cache_clr) begin
				cache_v_q <= 1'b0;
				cache_r_q <= '0;
			end else if (lk_cache_set) begin
				cache_v_q <= 1'b1;
				cache_r_q <= lk_r;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			ok_s1     <= lk_ok;
			type_s1   <= type_q;
			r_s1      <= lk_r;
			off_s1    <= diff[OFF_W-1:0];
			status_s1 <= lk_status;
			found_s1  <= lk_found;
		end
	end

	// word index by reciprocal multiply, exact for offsets below the heap size
	assign prod  = PRD_W'(off_s1) * RECIP_C;
	assign quot  = MEM_AW'(prod >> SH);
	assign raddr = MEM_AW'(MEM_AW'(r_s1) * WPH_C) + quot;

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			q_s2     <= quot;
			waddr_s2 <= raddr;
		end
	end

	assign bit_idx  = off_s1[BIT_W-1:0] - BIT_W'(BIT_W'(q_s2) * WB_LO);
	assign mask     = WORD_BITS'(1) << bit_idx;
	assign mod_data = (type_s1 == gmb_pkg::REQ_MARK) ? (rdata | mask) : (rdata & ~mask);
	assign mod_we   = cmd.finish && ok_s1 && (type_s1 != gmb_pkg::REQ_TEST);

	assign ram_we    = cmd.clr || mod_we;
	assign ram_waddr = cmd.clr ? clr_q : waddr_s2;
	assign ram_wdata = cmd.clr ? '0 : mod_data;
	assign ram_re    = cmd.rd && ok_s1;

	gmb_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MEM_D)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr && !clr_done) begin
			clr_q <= clr_q + MEM_AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			marked_q <= ok_s1 && (type_s1 == gmb_pkg::REQ_TEST) && rdata[bit_idx];
			status_q <= status_s1;
			found_q  <= found_s1;
		end
	end

endmodule

// ===== src/gc_mark_bitmap_unit_core.sv =====
// top level of the garbage collector mark bitmap unit
// each item goes through the lookup, bitmap ram read and read-modify-write states; its
// result is registered at the end of read-modify-write, one item at a time
// the next input is taken in the write-back cycle while the output register is free or being read
// reset: region table and cache invalid, then a bitmap clearing pass over all
// min(HEAPS, 8) * ceil(SLOTS_PER_HEAP / WORD_BITS) ram words (4096 by default) with s_tready low
module gc_mark_bitmap_unit_core #(
	parameter int HEAPS          = 8,
	parameter int SLOTS_PER_HEAP = 16384,
	parameter int WORD_BITS      = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// object_addr, heap_index, region_base, region_limit, region_enable, zero pad
	input  logic [gmb_pkg::IN_TDATA_W-1:0]    s_tdata,
	// req_type, heap_given
	input  logic [gmb_pkg::IN_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// marked, status, heap_found, zero pad
	output logic [gmb_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	gmb_pkg::gmb_cmd_t           cmd;
	logic                        clr_done;
	logic                        marked;
	logic [gmb_pkg::STAT_W-1:0]  status;
	logic [gmb_pkg::HIDX_W-1:0]  heap_found;

	assign m_tdata = {2'b00, heap_found, status, marked};

	gmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.clr_done (clr_done),
		.cmd      (cmd)
	);

	gmb_dpath #(
		.HEAPS          (HEAPS),
		.SLOTS_PER_HEAP (SLOTS_PER_HEAP),
		.WORD_BITS      (WORD_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.clr_done      (clr_done),
		.req_type      (s_tuser[2:0]),
		.object_addr   (s_tdata[31:0]),
		.heap_given    (s_tuser[3]),
		.heap_index    (s_tdata[34:32]),
		.region_base   (s_tdata[66:35]),
		.region_limit  (s_tdata[98:67]),
		.region_enable (s_tdata[99]),
		.marked        (marked),
		.status        (status),
		.heap_found    (heap_found)
	);

endmodule

// ===== src/gmb_chk.sv =====
// port checker for the mark bitmap unit and its bind
`include "gc_mark_bitmap_unit_core_defines.svh"

module gmb_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [gmb_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic s_xfer;

	assign s_xfer = s_tvalid && s_tready;

	// stalled result holds
	`GMB_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// one item at a time: no transfer right after a transfer
	`GMB_ASSERT_NEXT(a_no_back_to_back, clk, arst_n, s_xfer, !s_tready)
	// a transfer is not followed by a new result at the delayed check point of GMB_ASSERT_NEXT2
	`GMB_ASSERT_NEXT2(a_min_latency, clk, arst_n, s_xfer, !$rose(m_tvalid))

endmodule

bind gc_mark_bitmap_unit_core gmb_chk u_chk (.*);

// ===== bench/tb.sv =====
// self-checking testbench for the garbage collector mark bitmap unit
`timescale 1ns / 1ps

module tb;

	localparam int HEAPS_N   = 8;
	localparam int SLOTS_N   = 16384;
	localparam int WBITS_N   = 32;
	localparam int RAND_REQS = 840;

	typedef struct packed {
		logic [gmb_pkg::TYPE_W-1:0] kind;
		logic [31:0]                addr;
		logic                       given;
		logic [2:0]                 hidx;
		logic [31:0]                rbase;
		logic [31:0]                rlimit;
		logic                       ren;
	} gc_req_t;

	typedef struct packed {
		logic             marked;
		gmb_pkg::status_t status;
		logic [2:0]       heap;
	} gc_res_t;

	class gc_bitmap_sb;
		logic [31:0] base_tbl [HEAPS_N];
		logic [31:0] limit_tbl [HEAPS_N];
		bit          region_on [HEAPS_N];
		bit          cache_on;
		bit [2:0]    cache_idx;
		bit          mark_map [HEAPS_N*SLOTS_N];
		gc_res_t     pending_results [$];
		int          fail_count;
		int          result_count;

		function new();
			foreach (base_tbl[i]) begin
				base_tbl[i] = '0;
				limit_tbl[i] = '0;
				region_on[i] = 1'b0;
			end
			cache_on = 1'b0;
			cache_idx = '0;
			fail_count = 0;
			result_count = 0;
		endfunction

		function bit holds(bit [2:0] r, logic [31:0] a);
			return region_on[r] && a >= base_tbl[r] && a < limit_tbl[r];
		endfunction

		function gc_res_t lookup_and_update(gc_req_t q);
			gc_res_t r;
			bit hit;
			bit [2:0] sel;
			int bit_idx;
			r.marked = 1'b0;
			r.status = gmb_pkg::ST_OK;
			r.heap = '0;
			hit = 1'b0;
			sel = '0;
			if (q.kind == gmb_pkg::REQ_DEFINE) begin
				r.heap = q.hidx;
				if (!q.ren) begin
					region_on[q.hidx] = 1'b0;
					if (cache_on && cache_idx == q.hidx) begin
						cache_on = 1'b0;
						cache_idx = '0;
					end
				end else if (q.rlimit < q.rbase || q.rlimit - q.rbase > SLOTS_N) begin
					r.status = gmb_pkg::ST_TOO_LARGE;
				end else begin
					base_tbl[q.hidx] = q.rbase;
					limit_tbl[q.hidx] = q.rlimit;
					region_on[q.hidx] = 1'b1;
				end
			end else if (q.kind == gmb_pkg::REQ_FORGET) begin
				cache_on = 1'b0;
				cache_idx = '0;
			end else if (q.kind <= gmb_pkg::REQ_CLEAR) begin
				if (q.given) begin
					r.heap = q.hidx;
					if (holds(q.hidx, q.addr)) begin
						hit = 1'b1;
						sel = q.hidx;
						if (q.kind == gmb_pkg::REQ_TEST) begin
							cache_on = 1'b1;
							cache_idx = q.hidx;
						end
					end else begin
						r.status = gmb_pkg::ST_OUTSIDE;
					end
				end else if (cache_on && holds(cache_idx, q.addr)) begin
					hit = 1'b1;
					sel = cache_idx;
				end else begin
					for (int i = 0; i < HEAPS_N && !hit; i++) begin
						if (holds(3'(i), q.addr)) begin
							hit = 1'b1;
							sel = 3'(i);
							cache_on = 1'b1;
							cache_idx = 3'(i);
						end
					end
					if (!hit) r.status = gmb_pkg::ST_OFF_HEAP;
				end
				if (hit) begin
					bit_idx = sel * SLOTS_N + (q.addr - base_tbl[sel]);
					r.heap = sel;
					if (q.kind == gmb_pkg::REQ_MARK) mark_map[bit_idx] = 1'b1;
					else if (q.kind == gmb_pkg::REQ_CLEAR) mark_map[bit_idx] = 1'b0;
					else r.marked = mark_map[bit_idx];
				end
			end
			return r;
		endfunction

		function void note_request(gc_req_t q);
			pending_results.push_back(lookup_and_update(q));
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		task report_mismatch(string what);
			$display("mismatch at result %0d: %s", result_count, what);
			fail_count++;
		endtask

		task check_result(logic [gmb_pkg::OUT_TDATA_W-1:0] d);
			gc_res_t e;
			result_count++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing expected", d));
				return;
			end
			e = pending_results.pop_front();
			if (d[0] !== e.marked)
				report_mismatch($sformatf("marked %b, expected %b", d[0], e.marked));
			if (d[2:1] !== e.status)
				report_mismatch($sformatf("status %0d, expected %0d", d[2:1], e.status));
			if (d[5:3] !== e.heap)
				report_mismatch($sformatf("heap_found %0d, expected %0d", d[5:3], e.heap));
		endtask
	endclass

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [gmb_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic [gmb_pkg::IN_TUSER_W-1:0]  s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [gmb_pkg::OUT_TDATA_W-1:0] m_tdata;

	gc_bitmap_sb sb = new();
	bit          idle_tx = 1'b1;
	bit          idle_rx = 1'b1;

	gc_mark_bitmap_unit_core #(
		.HEAPS(HEAPS_N),
		.SLOTS_PER_HEAP(SLOTS_N),
		.WORD_BITS(WBITS_N)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	function automatic gc_req_t noise_req();
		gc_req_t q;
		q.kind = gmb_pkg::REQ_MARK;
		q.addr = $urandom;
		q.given = 1'($urandom);
		q.hidx = 3'($urandom);
		q.rbase = $urandom;
		q.rlimit = $urandom;
		q.ren = 1'($urandom);
		return q;
	endfunction

	function automatic gc_req_t define_req(logic [2:0] h, logic [31:0] b, logic [31:0] l, logic en);
		gc_req_t q;
		q = noise_req();
		q.kind = gmb_pkg::REQ_DEFINE;
		q.hidx = h;
		q.rbase = b;
		q.rlimit = l;
		q.ren = en;
		return q;
	endfunction

	function automatic gc_req_t access_req(logic [gmb_pkg::TYPE_W-1:0] k, logic [31:0] a,
			logic g, logic [2:0] h);
		gc_req_t q;
		q = noise_req();
		q.kind = k;
		q.addr = a;
		q.given = g;
		q.hidx = h;
		return q;
	endfunction

	function automatic gc_req_t random_define();
		int roll;
		int span;
		logic [31:0] b;
		roll = $urandom_range(0, 99);
		if (roll < 70) span = $urandom_range(1, 512);
		else if (roll < 80) span = $urandom_range(513, SLOTS_N);
		else if (roll < 85) span = SLOTS_N;
		else if (roll < 90) span = SLOTS_N + $urandom_range(1, 1000);
		else return define_req(3'($urandom), $urandom, $urandom, 1'b1);
		if ($urandom_range(0, 1)) b = $urandom_range(0, 8192);
		else b = $urandom_range(0, 32'hFFFF_FFFF - span);
		return define_req(3'($urandom), b, b + span, $urandom_range(0, 99) < 85);
	endfunction

	function automatic gc_req_t random_access(logic [gmb_pkg::TYPE_W-1:0] k);
		bit [2:0] live [$];
		bit [2:0] r;
		int roll;
		int span;
		logic [31:0] a;
		logic g;
		logic [2:0] h;
		for (int i = 0; i < HEAPS_N; i++)
			if (sb.region_on[i] && sb.limit_tbl[i] > sb.base_tbl[i]) live.push_back(3'(i));
		roll = $urandom_range(0, 99);
		r = live.size() > 0 ? live[$urandom_range(0, live.size() - 1)] : 3'($urandom);
		span = sb.limit_tbl[r] - sb.base_tbl[r];
		if (live.size() == 0 || roll < 15) begin
			a = $urandom;
		end else if (roll < 25) begin
			case ($urandom_range(0, 3))
				0: a = sb.base_tbl[r] - 1;
				1: a = sb.limit_tbl[r];
				2: a = sb.limit_tbl[r] - 1;
				default: a = sb.base_tbl[$urandom_range(0, HEAPS_N - 1)];
			endcase
		end else if (roll < 85) begin
			a = sb.base_tbl[r] + $urandom_range(0, span > 64 ? 63 : span - 1);
		end else begin
			a = sb.base_tbl[r] + $urandom_range(0, span - 1);
		end
		g = $urandom_range(0, 99) < 30;
		h = $urandom_range(0, 99) < 80 ? r : 3'($urandom_range(0, HEAPS_N - 1));
		return access_req(k, a, g, h);
	endfunction

	task send_item(gc_req_t q);
		int gap;
		gap = idle_tx ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, q.ren, q.rlimit, q.rbase, q.hidx, q.addr};
		s_tuser <= {q.given, q.kind};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_request(q);
	endtask

	task wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			sb.check_result(m_tdata);
	end

	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = idle_rx ? $urandom_range(0, 7) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
		end
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		int roll;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then region edges, refusals, overlap and cache handling
		send_item(access_req(gmb_pkg::REQ_TEST, 32'h0, 1'b0, 3'd0));
		send_item(access_req(gmb_pkg::REQ_MARK, 32'h0, 1'b1, 3'd0));
		send_item(define_req(3'd0, 32'h0, SLOTS_N, 1'b1));
		send_item(define_req(3'd1, 32'hFFFF_C000, 32'hFFFF_FFFF, 1'b1));
		send_item(define_req(3'd2, 32'd100, 32'd100 + SLOTS_N + 1, 1'b1));
		send_item(define_req(3'd3, 32'd500, 32'd400, 1'b1));
		send_item(access_req(gmb_pkg::REQ_MARK, 32'h0, 1'b0, 3'd7));
		send_item(access_req(gmb_pkg::REQ_TEST, 32'h0, 1'b0, 3'd7));
		send_item(access_req(gmb_pkg::REQ_MARK, 32'hFFFF_FFFE, 1'b0, 3'd0));
		send_item(access_req(gmb_pkg::REQ_TEST, 32'hFFFF_FFFE, 1'b1, 3'd1));
		send_item(access_req(gmb_pkg::REQ_TEST, 32'd5, 1'b1, 3'd1));
		send_item(access_req(gmb_pkg::REQ_CLEAR, 32'h0, 1'b0, 3'd0));
		send_item(access_req(gmb_pkg::REQ_TEST, 32'h0, 1'b0, 3'd0));
		send_item(access_req(gmb_pkg::REQ_TEST, SLOTS_N, 1'b0, 3'd0));
		send_item(define_req(3'd4, 32'h0, 32'd32, 1'b1));
		send_item(access_req(gmb_pkg::REQ_MARK, 32'd10, 1'b1, 3'd4));
		send_item(access_req(gmb_pkg::REQ_FORGET, 32'd10, 1'b0, 3'd0));
		send_item(define_req(3'd0, 32'h0, 32'h0, 1'b0));
		send_item(access_req(gmb_pkg::REQ_TEST, 32'd10, 1'b0, 3'd0));
		send_item(access_req(gmb_pkg::REQ_CLEAR, 32'd10, 1'b1, 3'd0));
		send_item(access_req(3'($urandom_range(gmb_pkg::REQ_FORGET + 1, 7)), $urandom, 1'b0,
			3'd0));
		send_item(access_req(3'd7, 32'hFFFF_FFFF, 1'b1, 3'd7));
		send_item(define_req(3'd5, 32'd70000, 32'd70000, 1'b1));
		send_item(access_req(gmb_pkg::REQ_TEST, 32'd70000, 1'b1, 3'd5));

		for (int i = 0; i < HEAPS_N; i++)
			send_item(define_req(3'(i), $urandom_range(0, 16384), 32'd0, 1'b1));
		for (int i = 0; i < HEAPS_N; i++) begin
			roll = $urandom_range(0, 8192);
			send_item(define_req(3'(i), roll, roll + $urandom_range(1, 4096), 1'b1));
		end

		for (int i = 0; i < RAND_REQS; i++) begin
			if (i % 100 == 0) begin
				idle_tx = (i / 100 == 2) ? 1'b0 : $urandom_range(0, 3) != 0;
				idle_rx = (i / 100 == 2) ? 1'b0 : $urandom_range(0, 3) != 0;
			end
			if (i == RAND_REQS / 2) wait_drained();
			roll = $urandom_range(0, 99);
			if (roll < 10) send_item(random_define());
			else if (roll < 13)
				send_item(access_req(gmb_pkg::REQ_FORGET, $urandom, 1'($urandom),
					3'($urandom)));
			else if (roll < 15)
				send_item(access_req(3'($urandom_range(gmb_pkg::REQ_FORGET + 1, 7)),
					$urandom, 1'($urandom), 3'($urandom)));
			else if (roll < 50) send_item(random_access(gmb_pkg::REQ_MARK));
			else if (roll < 80) send_item(random_access(gmb_pkg::REQ_TEST));
			else send_item(random_access(gmb_pkg::REQ_CLEAR));
		end

		s_tvalid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		if (sb.pending() > 0)
			sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
		if (sb.fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
